FILE: hdl/ors_pkg.sv
// ors_pkg: shared constants, command codes and controller/datapath interface types
// for the overwriting ring stack
// depends on: nothing
package ors_pkg;

	localparam int DEPTH   = 256;
	localparam int MAX_POP = 64;

	localparam int PTR_W   = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int REQ_W   = 7;
	localparam int DATA_W  = 8;
	localparam int CMD_W   = 2;
	localparam int ADDR_W  = 3;
	localparam int PDATA_W = 32;
	localparam int CMP_W   = (CNT_W > REQ_W) ? CNT_W : REQ_W;

	localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(DEPTH);

	// register index, taken from the word address bit
	localparam logic REG_CAPACITY = 1'b0;

	// command codes
	localparam logic [CMD_W-1:0] CMD_PUSH     = 2'd0;
	localparam logic [CMD_W-1:0] CMD_POP      = 2'd1;
	localparam logic [CMD_W-1:0] CMD_POP_MANY = 2'd2;

	// controller to datapath
	typedef struct packed {
		logic do_push;
		logic do_pop;
		logic do_many;
		logic issue_rd;
		logic load_direct;
		logic load_rd;
	} ors_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic fill_zero;
		logic n_zero;
		logic remain_one;
		logic pend;
		logic out_free;
	} ors_stat_t;

endpackage

FILE: hdl/ors_ram.sv
// ors_ram: generic single write port, single read port ram with registered read
// depends on: nothing
module ors_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: hdl/ors_ctrl.sv
// ors_ctrl: controller state machine, decodes commands and paces the pop-many stream
// depends on: ors_pkg
module ors_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [ors_pkg::CMD_W-1:0]  command,
	input  ors_pkg::ors_stat_t         stat,
	output ors_pkg::ors_cmd_t          cmd
);
	import ors_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE   = 2'b01,
		ST_STREAM = 2'b10
	} state_t;

	state_t state_q, state_d;
	logic   load_rd;

	assign load_rd  = stat.pend && stat.out_free;
	assign in_ready = (state_q == ST_IDLE) && !stat.pend && stat.out_free;

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.load_rd = load_rd;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && in_ready) begin
					case (command)
						CMD_PUSH: begin
							cmd.do_push     = 1'b1;
							cmd.load_direct = 1'b1;
						end
						CMD_POP: begin
							if (stat.fill_zero) begin
								cmd.load_direct = 1'b1;
							end else begin
								cmd.do_pop = 1'b1;
							end
						end
						CMD_POP_MANY: begin
							if (stat.n_zero) begin
								cmd.load_direct = 1'b1;
							end else begin
								cmd.do_many = 1'b1;
								state_d     = ST_STREAM;
							end
						end
						default: begin
							cmd.load_direct = 1'b1;
						end
					endcase
				end
			end
			ST_STREAM: begin
				// one read per cycle as long as the ram output stage drains
				if (!stat.pend || load_rd) begin
					cmd.issue_rd = 1'b1;
					if (stat.remain_one) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: hdl/ors_dp.sv
// ors_dp: datapath with capacity register, head pointer, fill count, ring ram,
// read stream counters and output register
// depends on: ors_pkg, ors_ram
module ors_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ors_pkg::ors_cmd_t            cmd,
	output ors_pkg::ors_stat_t           stat,
	input  logic [ors_pkg::DATA_W-1:0]   data_in,
	input  logic [ors_pkg::REQ_W-1:0]    pop_count,
	input  logic                         cfg_wr,
	input  logic [ors_pkg::PDATA_W-1:0]  cfg_wdata,
	output logic [ors_pkg::CNT_W-1:0]    cap_raw,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [ors_pkg::DATA_W-1:0]   data_out,
	output logic                         data_valid,
	output logic                         last,
	output logic [ors_pkg::CNT_W-1:0]    fill,
	output logic                         is_empty,
	output logic                         is_full
);
	import ors_pkg::*;

	logic [CNT_W-1:0]  cap_q, cap_eff, fill_q, fill_nxt;
	logic [PTR_W-1:0]  cap_m1, head_q, head_inc, head_dec, start, rd_ptr_q, rd_ptr_inc;
	logic [REQ_W-1:0]  req_c, n, remain_q;
	logic [CNT_W:0]    head_x, n_x, cap_x, start_x;
	logic              pend_q, pend_last_q, out_v_q, rd_en, load;
	logic [PTR_W-1:0]  raddr;
	logic [DATA_W-1:0] rdata;

	// clamp the programmed capacity into 1..DEPTH
	always_comb begin
		if (cap_q == '0) begin
			cap_eff = CNT_W'(1);
		end else if (cap_q > CNT_W'(DEPTH)) begin
			cap_eff = CNT_W'(DEPTH);
		end else begin
			cap_eff = cap_q;
		end
	end

	assign cap_m1     = PTR_W'(cap_eff - CNT_W'(1));
	assign head_inc   = (head_q == cap_m1) ? '0 : head_q + PTR_W'(1);
	assign head_dec   = (head_q == '0) ? cap_m1 : head_q - PTR_W'(1);
	assign rd_ptr_inc = (rd_ptr_q == cap_m1) ? '0 : rd_ptr_q + PTR_W'(1);

	assign req_c = (pop_count > REQ_W'(MAX_POP)) ? REQ_W'(MAX_POP) : pop_count;
	assign n     = (CMP_W'(req_c) < CMP_W'(fill_q)) ? req_c : REQ_W'(fill_q);

	// oldest of the n newest bytes
	assign head_x  = (CNT_W+1)'(head_q);
	assign n_x     = (CNT_W+1)'(n);
	assign cap_x   = (CNT_W+1)'(cap_eff);
	assign start_x = (head_x >= n_x) ? head_x - n_x : head_x + cap_x - n_x;
	assign start   = PTR_W'(start_x);

	always_comb begin
		fill_nxt = fill_q;
		if (cmd.do_push && (fill_q != cap_eff)) begin
			fill_nxt = fill_q + CNT_W'(1);
		end else if (cmd.do_pop) begin
			fill_nxt = fill_q - CNT_W'(1);
		end else if (cmd.do_many) begin
			fill_nxt = fill_q - CNT_W'(n);
		end
	end

	assign rd_en = cmd.do_pop || cmd.issue_rd;
	assign raddr = cmd.do_pop ? head_dec : rd_ptr_q;
	assign load  = cmd.load_direct || cmd.load_rd;

	ors_ram #(
		.WIDTH (DATA_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (cmd.do_push),
		.waddr (head_q),
		.wdata (data_in),
		.re    (rd_en),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= CAP_RESET;
			head_q      <= '0;
			fill_q      <= '0;
			rd_ptr_q    <= '0;
			remain_q    <= '0;
			pend_q      <= 1'b0;
			pend_last_q <= 1'b0;
			out_v_q     <= 1'b0;
		end else begin
			if (cfg_wr) begin
				cap_q  <= cfg_wdata[CNT_W-1:0];
				head_q <= '0;
				fill_q <= '0;
			end else begin
				if (cmd.do_push) begin
					head_q <= head_inc;
					fill_q <= fill_nxt;
				end
				if (cmd.do_pop) begin
					head_q <= head_dec;
					fill_q <= fill_nxt;
				end
				if (cmd.do_many) begin
					head_q   <= start;
					fill_q   <= fill_nxt;
					rd_ptr_q <= start;
					remain_q <= n;
				end
				if (cmd.issue_rd) begin
					rd_ptr_q <= rd_ptr_inc;
					remain_q <= remain_q - REQ_W'(1);
				end
			end
			if (rd_en) begin
				pend_q      <= 1'b1;
				pend_last_q <= cmd.do_pop || (remain_q == REQ_W'(1));
			end else if (cmd.load_rd) begin
				pend_q <= 1'b0;
			end
			if (load) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (cmd.load_direct) begin
			data_out   <= '0;
			data_valid <= 1'b0;
			last       <= 1'b1;
			fill       <= fill_nxt;
			is_empty   <= (fill_nxt == '0);
			is_full    <= (fill_nxt == cap_eff);
		end else if (cmd.load_rd) begin
			data_out   <= rdata;
			data_valid <= 1'b1;
			last       <= pend_last_q;
			fill       <= fill_q;
			is_empty   <= (fill_q == '0);
			is_full    <= (fill_q == cap_eff);
		end
	end

	assign out_valid       = out_v_q;
	assign cap_raw         = cap_q;
	assign stat.fill_zero  = (fill_q == '0);
	assign stat.n_zero     = (n == '0);
	assign stat.remain_one = (remain_q == REQ_W'(1));
	assign stat.pend       = pend_q;
	assign stat.out_free   = !out_v_q || out_ready;

`ifndef SYNTH
	a_fill_le_cap: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= cap_eff)
		else $error("fill count above capacity");
	a_head_in_ring: assert property (@(posedge clk) disable iff (!arst_n)
		CNT_W'(head_q) < cap_eff)
		else $error("head pointer outside ring");
	a_one_load: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.load_direct && cmd.load_rd))
		else $error("two results loaded in one cycle");
	a_pend_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q && !rd_en && cmd.load_rd) |=> !pend_q)
		else $error("read stage not released after load");
	a_remain_bound: assert property (@(posedge clk) disable iff (!arst_n)
		remain_q <= REQ_W'(MAX_POP))
		else $error("stream count above pop limit");
`endif

endmodule

FILE: hdl/overwriting_ring_stack.sv
// overwriting_ring_stack: top level, byte ring stack with overwrite of oldest entry
// depends on: ors_pkg, ors_ctrl, ors_dp (and ors_ram through ors_dp)
// results: push and empty results reach the output register in the cycle after accept;
//   a single pop goes through the registered ram read and then the output register;
//   pop-many streams one byte per cycle while the receiver accepts; a push or no-data
//   result every cycle likewise; the next command waits for the last popped byte
// reset: arst_n clears head pointer, fill count and the output stage and sets capacity to
//   256; ring storage is not cleared, there is no clearing pass
module overwriting_ring_stack (
	input  logic                          clk,
	input  logic                          arst_n,
	// input channel
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [ors_pkg::CMD_W-1:0]     command,
	input  logic [ors_pkg::DATA_W-1:0]    data_in,
	input  logic [ors_pkg::REQ_W-1:0]     pop_count,
	// result channel
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [ors_pkg::DATA_W-1:0]    data_out,
	output logic                          data_valid,
	output logic                          last,
	output logic [ors_pkg::CNT_W-1:0]     fill,
	output logic                          is_empty,
	output logic                          is_full,
	// apb configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ors_pkg::ADDR_W-1:0]    paddr,
	input  logic [ors_pkg::PDATA_W-1:0]   pwdata,
	output logic [ors_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready
);
	import ors_pkg::*;

	ors_cmd_t         cmd;
	ors_stat_t        stat;
	logic             cfg_wr;
	logic             cap_sel;
	logic [CNT_W-1:0] cap_raw;

	// zero wait state apb, one register at word 0
	assign pready  = 1'b1;
	assign cap_sel = (paddr[ADDR_W-1] == REG_CAPACITY);
	assign cfg_wr  = psel && penable && pwrite && cap_sel;
	assign prdata  = cap_sel ? PDATA_W'(cap_raw) : '0;

	// command decode and stream pacing
	ors_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.command  (command),
		.stat     (stat),
		.cmd      (cmd)
	);

	// pointers, counts, ring memory and output transaction register
	ors_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.data_in    (data_in),
		.pop_count  (pop_count),
		.cfg_wr     (cfg_wr),
		.cfg_wdata  (pwdata),
		.cap_raw    (cap_raw),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.data_out   (data_out),
		.data_valid (data_valid),
		.last       (last),
		.fill       (fill),
		.is_empty   (is_empty),
		.is_full    (is_full)
	);

endmodule

FILE: tb/testbench.sv
// testbench for overwriting_ring_stack: directed and random push, pop and pop-many
// traffic checked against a scoreboard that predicts every result
// depends on: ors_pkg, overwriting_ring_stack
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import ors_pkg::*;

	// command 3 has no package name, the block treats it as a no-op
	localparam logic [CMD_W-1:0]  CMD_UNUSED     = 2'd3;
	// capacity is register 0, byte address 0
	localparam logic [ADDR_W-1:0] ADDR_CAPACITY  = {REG_CAPACITY, 2'b00};
	// quiet cycles tolerated before the run is declared hung
	localparam int                WATCHDOG_LIMIT = 2000;
	// settle time after the last result before touching the register
	localparam int                SETTLE_CYCLES  = 4;

	// one result transaction, laid out in port order
	typedef struct packed {
		logic [DATA_W-1:0] data;
		logic              dv;
		logic              last;
		logic [CNT_W-1:0]  fill;
		logic              empty;
		logic              full;
	} ring_result_t;

	// predicts the ring and compares every result transaction in order
	class ring_scoreboard;
		logic [DATA_W-1:0] ring [DEPTH];
		int unsigned       head;
		int unsigned       level;
		logic [CNT_W-1:0]  cap_reg;
		ring_result_t      want_q[$];
		int                errors;
		int                checked;
		int                full_seen;

		function new();
			int i;
			head = 0;
			level = 0;
			cap_reg = CAP_RESET;
			errors = 0;
			checked = 0;
			full_seen = 0;
			for (i = 0; i < DEPTH; i++) ring[i] = '0;
		endfunction

		// out of range settings are clamped to 1..DEPTH
		function int unsigned cap_used();
			if (cap_reg == 0) return 1;
			if (cap_reg > DEPTH) return DEPTH;
			return 32'(cap_reg);
		endfunction

		// a capacity write restarts the ring
		function void write_capacity(logic [CNT_W-1:0] value);
			cap_reg = value;
			head = 0;
			level = 0;
		endfunction

		function int pending();
			return want_q.size();
		endfunction

		// status fields always reflect the level after the whole operation
		function void queue_result(logic [DATA_W-1:0] d, logic dv, logic lst);
			ring_result_t r;
			r.data = d;
			r.dv = dv;
			r.last = lst;
			r.fill = level[CNT_W-1:0];
			r.empty = (level == 0);
			r.full = (level == cap_used());
			want_q.push_back(r);
		endfunction

		function void note_input(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] d,
				logic [REQ_W-1:0] cnt);
			int unsigned cap;
			int unsigned req;
			int unsigned n;
			int unsigned pos;
			int unsigned i;
			logic [DATA_W-1:0] taken [MAX_POP];
			cap = cap_used();
			if (head >= cap) head = head % cap;
			if (level > cap) level = cap;
			case (cmd)
				CMD_PUSH: begin
					// full ring: oldest byte is overwritten, level saturates
					ring[head] = d;
					head = (head + 1) % cap;
					if (level < cap) level++;
					queue_result('0, 1'b0, 1'b1);
				end
				CMD_POP: begin
					if (level == 0) begin
						queue_result('0, 1'b0, 1'b1);
					end else begin
						head = (head == 0) ? cap - 1 : head - 1;
						level--;
						queue_result(ring[head], 1'b1, 1'b1);
					end
				end
				CMD_POP_MANY: begin
					req = (cnt > MAX_POP) ? MAX_POP : 32'(cnt);
					n = (req < level) ? req : level;
					if (n == 0) begin
						queue_result('0, 1'b0, 1'b1);
					end else begin
						// oldest of the n newest bytes comes out first
						pos = (head + cap - n) % cap;
						for (i = 0; i < n; i++) begin
							taken[i] = ring[pos];
							pos = (pos + 1) % cap;
						end
						head = (head + cap - n) % cap;
						level -= n;
						for (i = 0; i < n; i++) queue_result(taken[i], 1'b1, i + 1 == n);
					end
				end
				default: begin
					queue_result('0, 1'b0, 1'b1);
				end
			endcase
		endfunction

		task report(string what, logic [31:0] got, logic [31:0] want);
			errors++;
			// keep the log short on a badly broken block
			if (errors <= 100)
				$display("mismatch %s at %0t: got %0h, want %0h", what, $time, got, want);
		endtask

		task check_result(ring_result_t got);
			ring_result_t want;
			checked++;
			if (want_q.size() == 0) begin
				report("result with nothing pending", 32'(got), 0);
				return;
			end
			want = want_q.pop_front();
			if (want.full) full_seen++;
			if (got.data !== want.data) report("data_out", 32'(got.data), 32'(want.data));
			if (got.dv !== want.dv) report("data_valid", 32'(got.dv), 32'(want.dv));
			if (got.last !== want.last) report("last", 32'(got.last), 32'(want.last));
			if (got.fill !== want.fill) report("fill", 32'(got.fill), 32'(want.fill));
			if (got.empty !== want.empty)
				report("is_empty", 32'(got.empty), 32'(want.empty));
			if (got.full !== want.full) report("is_full", 32'(got.full), 32'(want.full));
		endtask
	endclass

	logic                clk = 1'b0;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic [CMD_W-1:0]    command;
	logic [DATA_W-1:0]   data_in;
	logic [REQ_W-1:0]    pop_count;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [DATA_W-1:0]   data_out;
	logic                data_valid;
	logic                last;
	logic [CNT_W-1:0]    fill;
	logic                is_empty;
	logic                is_full;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [PDATA_W-1:0]  pwdata;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	ring_scoreboard board;
	int                  send_idle_pct;
	int                  stall_pct;
	int                  items_in;
	int                  cap_writes;
	int                  quiet_cycles;

	overwriting_ring_stack u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.data_in(data_in),
		.pop_count(pop_count),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.data_out(data_out),
		.data_valid(data_valid),
		.last(last),
		.fill(fill),
		.is_empty(is_empty),
		.is_full(is_full),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// receiver backpressure, redrawn every cycle
	always @(posedge clk) begin
		out_ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
	end

	// outputs are stable from the falling edge up to the accepting rising edge,
	// so sampling here sees exactly the transaction that the next edge takes
	always @(negedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_result({data_out, data_valid, last, fill, is_empty, is_full});
	end

	// hang detection: any transaction on either channel resets the count
	always @(negedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= WATCHDOG_LIMIT) begin
					$display("timeout after %0d quiet cycles", quiet_cycles);
					$display("FAIL");
					$finish;
				end
			end
		end
	end

	// one input transaction; entered and left at a rising edge, valid held until taken
	task automatic send_item(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] d,
			logic [REQ_W-1:0] cnt);
		int gap;
		gap = 0;
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct && gap < 30) gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		data_in <= d;
		pop_count <= cnt;
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
		board.note_input(cmd, d, cnt);
		items_in++;
	endtask

	// sender holds off until every predicted result has been delivered
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (board.pending() > 0) @(posedge clk);
	endtask

	// apb write of the capacity register, only with the block idle
	task automatic write_capacity(logic [CNT_W-1:0] value);
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_CAPACITY;
		pwdata <= PDATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(negedge clk); while (!pready);
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		board.write_capacity(value);
		cap_writes++;
	endtask

	// one capacity setting: an optional push run to reach full, then mixed traffic
	task automatic run_phase(logic [CNT_W-1:0] cap_value, int idle_pct, int stall,
			int pushes, int count);
		int unsigned cap;
		int unsigned r;
		int i;
		logic [CMD_W-1:0] cmd;
		logic [REQ_W-1:0] cnt;
		write_capacity(cap_value);
		send_idle_pct = idle_pct;
		stall_pct = stall;
		repeat (pushes)
			send_item(CMD_PUSH, DATA_W'($urandom_range(255)), REQ_W'($urandom_range(127)));
		for (i = 0; i < count; i++) begin
			// halfway through, let the ring run dry of pending results
			if (i == count / 2) drain_results();
			cap = board.cap_used();
			r = $urandom_range(99);
			cnt = REQ_W'($urandom_range(127));
			if (r < 58) begin
				cmd = CMD_PUSH;
			end else if (r < 72) begin
				cmd = CMD_POP;
			end else if (r < 96) begin
				cmd = CMD_POP_MANY;
				// mostly counts up to just past the capacity, the rest anywhere up to the field max
				if (r < 90)
					cnt = REQ_W'($urandom_range((cap < MAX_POP) ? cap + 1 : MAX_POP, 0));
			end else begin
				cmd = CMD_UNUSED;
			end
			send_item(cmd, DATA_W'($urandom_range(255)), cnt);
		end
	endtask

	initial begin
		board = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		command = CMD_PUSH;
		data_in = '0;
		pop_count = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		send_idle_pct = 0;
		stall_pct = 0;
		items_in = 0;
		cap_writes = 0;
		quiet_cycles = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset state: capacity 256, ring empty
		send_item(CMD_PUSH, 8'h5a, 7'h7f);
		send_item(CMD_POP, 8'hff, 7'h00);
		send_item(CMD_POP_MANY, 8'h00, 7'd2);

		// tiny ring: empty pops, overwrite when full, oversized pop-many
		write_capacity(9'd3);
		send_item(CMD_POP, 8'h00, 7'h00);
		send_item(CMD_POP_MANY, 8'h00, 7'd5);
		send_item(CMD_UNUSED, 8'hff, 7'h7f);
		send_item(CMD_PUSH, 8'h00, 7'h00);
		send_item(CMD_PUSH, 8'hff, 7'h7f);
		send_item(CMD_PUSH, 8'h55, 7'h00);
		send_item(CMD_PUSH, 8'haa, 7'h00);
		send_item(CMD_POP, 8'h00, 7'h00);
		send_item(CMD_POP_MANY, 8'h00, 7'd0);
		send_item(CMD_POP_MANY, 8'h00, 7'h7f);
		send_item(CMD_POP, 8'h00, 7'h00);
		send_item(CMD_PUSH, 8'h01, 7'h00);
		send_item(CMD_PUSH, 8'h02, 7'h00);
		send_item(CMD_PUSH, 8'h03, 7'h00);
		send_item(CMD_PUSH, 8'h04, 7'h00);
		send_item(CMD_POP_MANY, 8'h00, 7'd64);
		send_item(CMD_PUSH, 8'h80, 7'h00);
		send_item(CMD_POP_MANY, 8'h00, 7'd1);

		// capacity 0 behaves as a one-entry ring
		write_capacity(9'd0);
		send_item(CMD_PUSH, 8'h7f, 7'h00);
		send_item(CMD_PUSH, 8'h80, 7'h00);
		send_item(CMD_POP, 8'h00, 7'h00);
		send_item(CMD_POP, 8'h00, 7'h00);
		send_item(CMD_PUSH, 8'hfe, 7'h00);
		send_item(CMD_POP_MANY, 8'h00, 7'd3);

		// random part, each phase with its own capacity and idling mix
		run_phase(9'd511, 0, 0, 258, 12);
		run_phase(9'd1, 50, 0, 0, 30);
		run_phase(9'd2, 0, 50, 0, 30);
		run_phase(CNT_W'($urandom_range(40, 3)), 18, 18, 0, 40);
		run_phase(CAP_RESET, 18, 18, 0, 13);

		drain_results();
		repeat (10) @(posedge clk);
		if (board.pending() != 0) board.report("results never delivered", board.pending(), 0);

		$display("covered %0d input and %0d result transactions over %0d capacity settings",
			items_in, board.checked, cap_writes);
		$display("%0d results came with the ring full, %0d mismatches", board.full_seen,
			board.errors);
		if (board.errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
